/* rtl/text_console_cursor_engine_unit_defines.svh */
// Assertion macros used by the checker of the text console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH

// Implication checked at every edge outside reset.
`define TCCE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked at the next edge, outside reset.
`define TCCE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked at the next edge that is also checked while reset is asserted.
`define TCCE_ASSERT_NXT_ALWAYS(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcce_pkg.sv */
// Types, constants and control structures of the text console cursor engine.
package tcce_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = ROWS * COLUMNS;
    localparam int MOVED_COUNT = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);

    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CHAR_W   = 8;
    localparam int COLOUR_W = 4;
    localparam int CELL_W   = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam int                TAB_STEP     = 3;

    localparam logic [COLOUR_W-1:0] RESET_BG = 4'd0;
    localparam logic [COLOUR_W-1:0] RESET_FG = 4'd7;
    localparam logic [CELL_W-1:0]   RESET_BLANK = {RESET_BG, RESET_FG, CH_BLANK};

    localparam logic CFG_BACKGROUND = 1'b0;
    localparam logic CFG_FOREGROUND = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [ROW_W:0]    t_row_ext;
    typedef logic [COL_W:0]    t_col_ext;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_EXEC,
        WR_COPY,
        WR_BLANK
    } t_wr_mode;

    typedef struct packed {
        logic     latch_in;
        logic     exec;
        logic     rd_capture;
        logic     ptr_clr;
        logic     ptr_inc;
        logic     load_out;
        t_wr_mode wr_mode;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic need_scroll;
        logic ptr_last;
        logic ptr_moved;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [1:0]       pad;
        logic [COL_W-1:0] read_col;
        logic [ROW_W-1:0] read_row;
        logic [CHAR_W-1:0] char_code;
        logic [1:0]       command;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        pad;
        logic              scrolled;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_value;
    } t_out_item;

endpackage

/* rtl/tcce_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcce_ctrl.sv */
// Controller state machine that sequences commands, screen sweeps and result hand-off.
module tcce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcce_pkg::t_dp_stat i_stat,
    output tcce_pkg::t_dp_cmd  o_cmd
);

    tcce_pkg::t_state r_state;
    tcce_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcce_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.wr_mode    = tcce_pkg::WR_NONE;
        unique case (r_state)
            tcce_pkg::ST_INIT: begin
                o_cmd.wr_mode = tcce_pkg::WR_INIT;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = tcce_pkg::ST_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            tcce_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = tcce_pkg::ST_EXEC;
                end
            end
            tcce_pkg::ST_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.wr_mode = tcce_pkg::WR_EXEC;
                unique case (i_stat.cmd)
                    tcce_pkg::CMD_PUT: begin
                        n_state = i_stat.need_scroll ? tcce_pkg::ST_COPY : tcce_pkg::ST_DONE;
                    end
                    tcce_pkg::CMD_CLEAR: n_state = tcce_pkg::ST_CLEAR;
                    tcce_pkg::CMD_READ:  n_state = tcce_pkg::ST_READ;
                    default:             n_state = tcce_pkg::ST_DONE;
                endcase
            end
            tcce_pkg::ST_READ: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = tcce_pkg::ST_DONE;
            end
            tcce_pkg::ST_COPY: begin
                o_cmd.wr_mode = tcce_pkg::WR_COPY;
                if (i_stat.ptr_moved) begin
                    n_state = tcce_pkg::ST_BLANK;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            tcce_pkg::ST_BLANK, tcce_pkg::ST_CLEAR: begin
                o_cmd.wr_mode = tcce_pkg::WR_BLANK;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = tcce_pkg::ST_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            tcce_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = tcce_pkg::ST_IDLE;
                end
            end
            default: n_state = tcce_pkg::ST_INIT;
        endcase
    end

endmodule

/* rtl/tcce_dp.sv */
// Datapath with cursor logic, colour registers, sweep pointer, screen store and output register.
module tcce_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tcce_pkg::t_dp_cmd                     i_cmd,
    output tcce_pkg::t_dp_stat                    o_stat,
    input  logic [tcce_pkg::IN_TDATA_W-1:0]       i_in_data,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_index,
    input  logic [tcce_pkg::COLOUR_W-1:0]         i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [tcce_pkg::OUT_TDATA_W-1:0]      o_out_data
);

    tcce_pkg::t_in_item in_item;

    tcce_pkg::t_cmd                  r_cmd;
    logic [tcce_pkg::CHAR_W-1:0]     r_char;
    logic [tcce_pkg::ROW_W-1:0]      r_rrow;
    logic [tcce_pkg::COL_W-1:0]      r_rcol;
    logic [tcce_pkg::ROW_W-1:0]      r_cur_row;
    logic [tcce_pkg::COL_W-1:0]      r_cur_col;
    logic [tcce_pkg::COLOUR_W-1:0]   r_bg;
    logic [tcce_pkg::COLOUR_W-1:0]   r_fg;
    tcce_pkg::t_addr                 r_ptr;
    logic                            r_scrolled;
    logic [tcce_pkg::CELL_W-1:0]     r_cell;
    logic                            r_out_valid;
    tcce_pkg::t_out_item             r_out;

    tcce_pkg::t_addr                 cur_idx;
    tcce_pkg::t_addr                 rd_idx;
    logic                            rd_in_range;
    tcce_pkg::t_row_ext              row_step;
    tcce_pkg::t_col_ext              col_step;
    logic                            put_we;
    tcce_pkg::t_addr                 put_addr;
    logic [tcce_pkg::CHAR_W-1:0]     put_char;
    logic                            need_scroll;
    logic [tcce_pkg::ROW_W-1:0]      new_row;
    logic [tcce_pkg::COL_W-1:0]      new_col;
    logic [tcce_pkg::CELL_W-1:0]     blank_cell;

    logic                            ram_we;
    tcce_pkg::t_addr                 ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]     ram_wdata;
    tcce_pkg::t_addr                 ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]     ram_rdata;

    assign in_item    = i_in_data;
    assign blank_cell = {r_bg, r_fg, tcce_pkg::CH_BLANK};

    assign cur_idx = tcce_pkg::t_addr'(r_cur_row) * tcce_pkg::t_addr'(tcce_pkg::COLUMNS)
                   + tcce_pkg::t_addr'(r_cur_col);
    assign rd_idx  = tcce_pkg::t_addr'(r_rrow) * tcce_pkg::t_addr'(tcce_pkg::COLUMNS)
                   + tcce_pkg::t_addr'(r_rcol);
    assign rd_in_range = (r_rrow < tcce_pkg::ROWS) && (r_rcol < tcce_pkg::COLUMNS);

    always_comb begin
        row_step = tcce_pkg::t_row_ext'(r_cur_row);
        col_step = tcce_pkg::t_col_ext'(r_cur_col);
        put_we   = 1'b0;
        put_addr = cur_idx;
        put_char = r_char;
        if (r_char == tcce_pkg::CH_NEWLINE) begin
            row_step = row_step + 1'b1;
            col_step = '0;
        end else if (r_char == tcce_pkg::CH_TAB) begin
            col_step = col_step + tcce_pkg::t_col_ext'(tcce_pkg::TAB_STEP);
        end else if (r_char == tcce_pkg::CH_BACKSPACE) begin
            if (cur_idx != '0) begin
                put_we   = 1'b1;
                put_addr = cur_idx - 1'b1;
                put_char = tcce_pkg::CH_BLANK;
                if (r_cur_col == '0) begin
                    col_step = tcce_pkg::t_col_ext'(tcce_pkg::COLUMNS - 1);
                    row_step = row_step - 1'b1;
                end else begin
                    col_step = col_step - 1'b1;
                end
            end
        end else begin
            put_we   = 1'b1;
            col_step = col_step + 1'b1;
        end
        if (col_step >= tcce_pkg::t_col_ext'(tcce_pkg::COLUMNS)) begin
            col_step = '0;
            row_step = row_step + 1'b1;
        end
        need_scroll = row_step >= tcce_pkg::t_row_ext'(tcce_pkg::ROWS);
        new_row     = need_scroll ? tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)
                                  : row_step[tcce_pkg::ROW_W-1:0];
        new_col     = col_step[tcce_pkg::COL_W-1:0];
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = blank_cell;
        unique case (i_cmd.wr_mode)
            tcce_pkg::WR_NONE: ram_we = 1'b0;
            tcce_pkg::WR_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = tcce_pkg::RESET_BLANK;
            end
            tcce_pkg::WR_EXEC: begin
                ram_we    = put_we && (r_cmd == tcce_pkg::CMD_PUT);
                ram_waddr = put_addr;
                ram_wdata = {r_bg, r_fg, put_char};
            end
            tcce_pkg::WR_COPY: begin
                ram_we    = r_ptr != '0;
                ram_waddr = r_ptr - 1'b1;
                ram_wdata = ram_rdata;
            end
            tcce_pkg::WR_BLANK: ram_we = 1'b1;
            default: ram_we = 1'b0;
        endcase
    end

    assign ram_raddr = (i_cmd.wr_mode == tcce_pkg::WR_COPY)
                     ? r_ptr + tcce_pkg::t_addr'(tcce_pkg::COLUMNS) : rd_idx;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_bg        <= tcce_pkg::RESET_BG;
            r_fg        <= tcce_pkg::RESET_FG;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == tcce_pkg::CFG_BACKGROUND) begin
                    r_bg <= i_cfg_data;
                end else begin
                    r_fg <= i_cfg_data;
                end
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.exec) begin
                if (r_cmd == tcce_pkg::CMD_PUT) begin
                    r_cur_row <= new_row;
                    r_cur_col <= new_col;
                end else if (r_cmd == tcce_pkg::CMD_CLEAR) begin
                    r_cur_row <= '0;
                    r_cur_col <= '0;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd  <= tcce_pkg::t_cmd'(in_item.command);
            r_char <= in_item.char_code;
            r_rrow <= in_item.read_row;
            r_rcol <= in_item.read_col;
        end
        if (i_cmd.exec) begin
            r_scrolled <= (r_cmd == tcce_pkg::CMD_PUT) && need_scroll;
            r_cell     <= '0;
        end else if (i_cmd.rd_capture) begin
            r_cell <= rd_in_range ? ram_rdata : '0;
        end
        if (i_cmd.load_out) begin
            r_out.pad        <= '0;
            r_out.scrolled   <= r_scrolled;
            r_out.cursor_col <= r_cur_col;
            r_out.cursor_row <= r_cur_row;
            r_out.cell_value <= r_cell;
        end
    end

    assign o_stat.cmd         = r_cmd;
    assign o_stat.need_scroll = need_scroll;
    assign o_stat.ptr_last    = r_ptr == tcce_pkg::t_addr'(tcce_pkg::CELL_COUNT - 1);
    assign o_stat.ptr_moved   = r_ptr == tcce_pkg::t_addr'(tcce_pkg::MOVED_COUNT);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/text_console_cursor_engine_unit.sv */
// Top level of the text console cursor engine.
//
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  command, char_code, read_row, read_col
// m_axis    out        m_axis_tvalid / m_axis_tready  cell_value, cursor_row, cursor_col, scrolled
// cfg       in         i_cfg_valid / o_cfg_ready      register index and colour code
//
// A put or an unused command runs through the execute and done states, a read through
// execute, read and done; a new transfer is taken only once the engine is back in idle.
// A put that scrolls walks the screen store: it copies each row up, then blanks the last row.
// A clear blanks one cell per cycle over the whole screen store.
// After reset a clearing pass over all ROWS * COLUMNS cells (2000) runs before s_axis_tready rises.
// A stalled result waits in the output register; the next item may still be taken.
module text_console_cursor_engine_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // command[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zero fill
    input  logic [tcce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28], zero fill
    output logic [tcce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [tcce_pkg::COLOUR_W-1:0]       i_cfg_data
);

    tcce_pkg::t_dp_cmd  dp_cmd;
    tcce_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    tcce_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* rtl/tcce_checker.sv */
// Port-level checker for the text console cursor engine and its bind statement.
`include "text_console_cursor_engine_unit_defines.svh"

module tcce_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tcce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    tcce_pkg::t_out_item out_item;
    logic                stall;
    logic                cursor_ok;
    logic                last_row;

    assign out_item  = m_axis_tdata;
    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign cursor_ok = (out_item.cursor_row < tcce_pkg::ROWS)
                    && (out_item.cursor_col < tcce_pkg::COLUMNS);
    assign last_row  = out_item.cursor_row == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);

    `TCCE_ASSERT_NXT(a_out_hold, stall, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `TCCE_ASSERT_IMP(a_cursor_range, m_axis_tvalid, cursor_ok, "cursor outside the screen")
    `TCCE_ASSERT_IMP(a_scroll_row, m_axis_tvalid && out_item.scrolled, last_row, "scroll off last row")
    `TCCE_ASSERT_NXT_ALWAYS(a_init_pass, !i_rst_n, !s_axis_tready, "input taken during clearing")

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);

/* tb/text_console_cursor_engine_unit_test.sv */
// Self-checking testbench for the text console cursor engine against a predictor.
`timescale 1ns / 1ps

module text_console_cursor_engine_unit_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PERCENT = 21;
    localparam int PHASE_ITEMS = 180;
    localparam int DRAIN_CYCLES = 50;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [tcce_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [tcce_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic                              i_cfg_index = tcce_pkg::CFG_BACKGROUND;
    logic [tcce_pkg::COLOUR_W-1:0]     i_cfg_data = '0;

    logic [tcce_pkg::CELL_W-1:0]   screen_model [tcce_pkg::CELL_COUNT];
    logic [tcce_pkg::COLOUR_W-1:0] model_bg;
    logic [tcce_pkg::COLOUR_W-1:0] model_fg;
    int                            model_row;
    int                            model_col;

    tcce_pkg::t_out_item expected_reports[$];
    int                  mismatch_count = 0;
    int                  items_accepted = 0;
    bit                  no_idle = 1'b0;
    int unsigned         cycle_count = 0;

    text_console_cursor_engine_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [tcce_pkg::CELL_W-1:0] coloured_cell(
        input logic [tcce_pkg::CHAR_W-1:0] ch);
        return {model_bg, model_fg, ch};
    endfunction

    function automatic void blank_screen_model();
        for (int i = 0; i < tcce_pkg::CELL_COUNT; i++) begin
            screen_model[i] = coloured_cell(tcce_pkg::CH_BLANK);
        end
    endfunction

    // Applies one item to the screen model and returns the report it must produce.
    function automatic tcce_pkg::t_out_item model_console_item(input tcce_pkg::t_in_item item);
        tcce_pkg::t_out_item report;
        int                  idx;
        report = '0;
        idx = model_row * tcce_pkg::COLUMNS + model_col;
        case (item.command)
            tcce_pkg::CMD_PUT: begin
                if (item.char_code == tcce_pkg::CH_NEWLINE) begin
                    model_row++;
                    model_col = 0;
                end else if (item.char_code == tcce_pkg::CH_TAB) begin
                    model_col += tcce_pkg::TAB_STEP;
                end else if (item.char_code == tcce_pkg::CH_BACKSPACE) begin
                    if (idx != 0) begin
                        screen_model[idx - 1] = coloured_cell(tcce_pkg::CH_BLANK);
                        if (model_col == 0) begin
                            model_col = tcce_pkg::COLUMNS - 1;
                            model_row--;
                        end else begin
                            model_col--;
                        end
                    end
                end else begin
                    screen_model[idx] = coloured_cell(item.char_code);
                    model_col++;
                end
                if (model_col >= tcce_pkg::COLUMNS) begin
                    model_col = 0;
                    model_row++;
                end
                if (model_row >= tcce_pkg::ROWS) begin
                    for (int i = 0; i < tcce_pkg::MOVED_COUNT; i++) begin
                        screen_model[i] = screen_model[i + tcce_pkg::COLUMNS];
                    end
                    for (int i = tcce_pkg::MOVED_COUNT; i < tcce_pkg::CELL_COUNT; i++) begin
                        screen_model[i] = coloured_cell(tcce_pkg::CH_BLANK);
                    end
                    model_row = tcce_pkg::ROWS - 1;
                    report.scrolled = 1'b1;
                end
            end
            tcce_pkg::CMD_CLEAR: begin
                blank_screen_model();
                model_row = 0;
                model_col = 0;
            end
            tcce_pkg::CMD_READ: begin
                if (int'(item.read_row) < tcce_pkg::ROWS &&
                    int'(item.read_col) < tcce_pkg::COLUMNS) begin
                    report.cell_value = screen_model[int'(item.read_row) * tcce_pkg::COLUMNS
                                                     + int'(item.read_col)];
                end
            end
            default: begin
            end
        endcase
        report.cursor_row = tcce_pkg::ROW_W'(model_row);
        report.cursor_col = tcce_pkg::COL_W'(model_col);
        return report;
    endfunction

    task automatic check_report(input tcce_pkg::t_out_item got);
        tcce_pkg::t_out_item want;
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result, actual cell %h row %0d col %0d scrolled %0b",
                     $time, got.cell_value, got.cursor_row, got.cursor_col, got.scrolled);
            mismatch_count++;
        end else begin
            want = expected_reports.pop_front();
            if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
                got.cursor_col !== want.cursor_col || got.scrolled !== want.scrolled) begin
                $display("%0t: mismatch, expected cell %h row %0d col %0d scrolled %0b",
                         $time, want.cell_value, want.cursor_row, want.cursor_col,
                         want.scrolled);
                $display("%0t:           actual   cell %h row %0d col %0d scrolled %0b",
                         $time, got.cell_value, got.cursor_row, got.cursor_col, got.scrolled);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_report(tcce_pkg::t_out_item'(m_axis_tdata));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("text_console_cursor_engine_unit_test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [tcce_pkg::CHAR_W-1:0] ch,
                             input logic [tcce_pkg::ROW_W-1:0] row,
                             input logic [tcce_pkg::COL_W-1:0] col);
        tcce_pkg::t_in_item item;
        item = '0;
        item.command = cmd;
        item.char_code = ch;
        item.read_row = row;
        item.read_col = col;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= item;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_reports.push_back(model_console_item(item));
        items_accepted++;
    endtask

    task automatic put_byte(input logic [tcce_pkg::CHAR_W-1:0] ch);
        send_item(tcce_pkg::CMD_PUT, ch, tcce_pkg::ROW_W'($urandom_range(31)),
                  tcce_pkg::COL_W'($urandom_range(127)));
    endtask

    task automatic read_cell(input logic [tcce_pkg::ROW_W-1:0] row,
                             input logic [tcce_pkg::COL_W-1:0] col);
        send_item(tcce_pkg::CMD_READ, tcce_pkg::CHAR_W'($urandom_range(255)), row, col);
    endtask

    task automatic clear_screen();
        send_item(tcce_pkg::CMD_CLEAR, tcce_pkg::CHAR_W'($urandom_range(255)),
                  tcce_pkg::ROW_W'($urandom_range(31)), tcce_pkg::COL_W'($urandom_range(127)));
    endtask

    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Both colour registers are written back to back; the stream side must be drained.
    task automatic set_colours(input logic [tcce_pkg::COLOUR_W-1:0] bg,
                               input logic [tcce_pkg::COLOUR_W-1:0] fg);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tcce_pkg::CFG_BACKGROUND;
        i_cfg_data <= bg;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        model_bg = bg;
        i_cfg_index <= tcce_pkg::CFG_FOREGROUND;
        i_cfg_data <= fg;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        model_fg = fg;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_screen();
        read_cell(5'd0, 7'd0);
        read_cell(5'd24, 7'd79);
        read_cell(5'd25, 7'd0);
        read_cell(5'd0, 7'd80);
        read_cell(5'd31, 7'd127);
        send_item(CMD_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    endtask

    task automatic test_control_chars();
        clear_screen();
        put_byte(tcce_pkg::CH_BACKSPACE);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h7F);
        put_byte(tcce_pkg::CH_TAB);
        put_byte(tcce_pkg::CH_BACKSPACE);
        put_byte(tcce_pkg::CH_NEWLINE);
        put_byte(tcce_pkg::CH_BACKSPACE);
        put_byte(tcce_pkg::CH_TAB);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd79);
    endtask

    task automatic test_colour_extremes();
        wait_for_reports();
        set_colours(4'hF, 4'h0);
        put_byte(8'h41);
        read_cell(5'd1, 7'd0);
        wait_for_reports();
        set_colours(4'h0, 4'hF);
        clear_screen();
        put_byte(8'h5A);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
    endtask

    // Mostly short text lines so the cursor reaches the bottom row and scrolls often.
    task automatic test_random_traffic();
        int target;
        int pick;
        int len;
        for (int phase = 0; phase < 4; phase++) begin
            wait_for_reports();
            set_colours(tcce_pkg::COLOUR_W'($urandom_range(15)),
                        tcce_pkg::COLOUR_W'($urandom_range(15)));
            no_idle = (phase == 2);
            target = items_accepted + PHASE_ITEMS;
            while (items_accepted < target) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(6);
                    repeat (len) put_byte(tcce_pkg::CHAR_W'($urandom_range(255)));
                    put_byte(tcce_pkg::CH_NEWLINE);
                end else if (pick < 65) begin
                    repeat ($urandom_range(4, 1)) put_byte(tcce_pkg::CH_TAB);
                end else if (pick < 75) begin
                    repeat ($urandom_range(6, 1)) put_byte(tcce_pkg::CH_BACKSPACE);
                end else if (pick < 93) begin
                    repeat ($urandom_range(4, 1)) begin
                        if ($urandom_range(7) == 0) begin
                            read_cell(tcce_pkg::ROW_W'($urandom_range(31)),
                                      tcce_pkg::COL_W'($urandom_range(127)));
                        end else begin
                            read_cell(tcce_pkg::ROW_W'($urandom_range(tcce_pkg::ROWS - 1)),
                                      tcce_pkg::COL_W'($urandom_range(tcce_pkg::COLUMNS - 1)));
                        end
                    end
                end else if (pick < 99) begin
                    send_item(CMD_UNUSED, tcce_pkg::CHAR_W'($urandom_range(255)),
                              tcce_pkg::ROW_W'($urandom_range(31)),
                              tcce_pkg::COL_W'($urandom_range(127)));
                end else begin
                    clear_screen();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        model_bg = tcce_pkg::RESET_BG;
        model_fg = tcce_pkg::RESET_FG;
        model_row = 0;
        model_col = 0;
        blank_screen_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_screen();
        test_control_chars();
        test_colour_extremes();
        test_random_traffic();
        wait_for_reports();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("text_console_cursor_engine_unit_test passed");
        end else begin
            $display("text_console_cursor_engine_unit_test failed");
        end
        $finish;
    end

endmodule
